### sv/sfcr_pkg.sv
// Types and constants shared by the serial frame checker and router.
// No dependencies; every other file imports this package.
package sfcr_pkg;

    localparam logic [7:0] SYNC_FIRST  = 8'hFF;
    localparam logic [7:0] SYNC_SECOND = 8'h55;
    localparam logic [7:0] MIN_LENGTH  = 8'd3;

    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ACK_INTENT = 2'd0,
        CFG_APP_A      = 2'd1,
        CFG_APP_B      = 2'd2,
        CFG_APP_C      = 2'd3
    } t_cfg_idx;

    typedef enum logic [1:0] {
        ROUTE_DROP = 2'd0,
        ROUTE_ACK  = 2'd1,
        ROUTE_APP  = 2'd2
    } t_route;

    localparam int unsigned ERR_SYNC   = 0;
    localparam int unsigned ERR_LENGTH = 1;
    localparam int unsigned ERR_CSUM   = 2;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_req;

    typedef struct packed {
        logic [2:0] error_flags;
        logic [7:0] frame_intent;
        logic [7:0] frame_counter;
        logic [7:0] body_length;
        logic [1:0] route;
        logic       ack_request;
    } t_out_rsp;

    typedef struct packed {
        logic [7:0] ack_intent_code;
        logic [7:0] app_intent_a;
        logic [7:0] app_intent_b;
        logic [7:0] app_intent_c;
    } t_cfg;

endpackage

### sv/sfcr_cfg_regs.sv
// Configuration registers of the frame checker: intent codes for routing.
// Depends on sfcr_pkg.
module sfcr_cfg_regs
    import sfcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data,
    output t_cfg                 o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_ACK_INTENT: n_cfg.ack_intent_code = i_cfg_data;
                CFG_APP_A:      n_cfg.app_intent_a    = i_cfg_data;
                CFG_APP_B:      n_cfg.app_intent_b    = i_cfg_data;
                CFG_APP_C:      n_cfg.app_intent_c    = i_cfg_data;
                default:        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### sv/sfcr_frame_track.sv
// Frame state tracker: byte position, length, body sum, counter and intent,
// plus the verdict formed on the checksum byte. Depends on sfcr_pkg.
module sfcr_frame_track
    import sfcr_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_accept,
    input  t_in_req  i_req,
    input  t_cfg     i_cfg,
    output logic     o_verdict,
    output t_out_rsp o_rsp
);

    logic       r_in_frame;
    logic [8:0] r_pos;
    logic [7:0] r_len;
    logic [7:0] r_sum;
    logic       r_sync_bad;
    logic [7:0] r_cnt;
    logic [7:0] r_intent;

    logic       n_in_frame;
    logic [8:0] n_pos;
    logic [7:0] n_len;
    logic [7:0] n_sum;
    logic       n_sync_bad;
    logic [7:0] n_cnt;
    logic [7:0] n_intent;

    logic       b_in_frame;
    logic [8:0] b_pos;
    logic [7:0] b_len;
    logic [7:0] b_sum;
    logic       b_sync_bad;
    logic [7:0] b_cnt;
    logic [7:0] b_intent;
    logic [8:0] csum_pos;
    logic [7:0] csum_exp;
    logic [2:0] err;
    logic       verdict;
    t_out_rsp   rsp;

    always_comb begin
        // restart on a start marker
        if (i_req.frame_start) begin
            b_in_frame = 1'b1;
            b_pos      = '0;
            b_len      = '0;
            b_sum      = '0;
            b_sync_bad = 1'b0;
            b_cnt      = '0;
            b_intent   = '0;
        end else begin
            b_in_frame = r_in_frame;
            b_pos      = r_pos;
            b_len      = r_len;
            b_sum      = r_sum;
            b_sync_bad = r_sync_bad;
            b_cnt      = r_cnt;
            b_intent   = r_intent;
        end

        csum_pos = {1'b0, b_len} + 9'd3;
        csum_exp = 8'h00 - b_sum;

        n_in_frame = b_in_frame;
        n_pos      = b_pos;
        n_len      = b_len;
        n_sum      = b_sum;
        n_sync_bad = b_sync_bad;
        n_cnt      = b_cnt;
        n_intent   = b_intent;
        verdict    = 1'b0;

        if (b_in_frame) begin
            n_pos = b_pos + 9'd1;
            if (b_pos == 9'd0) begin
                if (i_req.rx_byte != SYNC_FIRST) n_sync_bad = 1'b1;
            end else if (b_pos == 9'd1) begin
                if (i_req.rx_byte != SYNC_SECOND) n_sync_bad = 1'b1;
            end else if (b_pos == 9'd2) begin
                n_len = i_req.rx_byte;
            end else if (b_pos < csum_pos) begin
                n_sum = b_sum + i_req.rx_byte;
                if (b_pos == 9'd3) n_cnt = i_req.rx_byte;
                if (b_pos == 9'd4) n_intent = i_req.rx_byte;
            end else begin
                verdict    = 1'b1;
                n_in_frame = 1'b0;
                n_pos      = '0;
            end
        end

        err             = '0;
        err[ERR_SYNC]   = b_sync_bad;
        err[ERR_LENGTH] = (b_len < MIN_LENGTH);
        err[ERR_CSUM]   = (i_req.rx_byte != csum_exp);

        rsp.error_flags   = err;
        rsp.frame_intent  = b_intent;
        rsp.frame_counter = b_cnt;
        rsp.body_length   = b_len;
        rsp.route         = ROUTE_DROP;
        rsp.ack_request   = 1'b0;
        if (err == 3'd0) begin
            if (b_intent == i_cfg.ack_intent_code) begin
                rsp.route = ROUTE_ACK;
            end else begin
                rsp.ack_request = 1'b1;
                if (b_intent == i_cfg.app_intent_a || b_intent == i_cfg.app_intent_b ||
                    b_intent == i_cfg.app_intent_c) begin
                    rsp.route = ROUTE_APP;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame <= 1'b0;
            r_pos      <= '0;
            r_len      <= '0;
            r_sum      <= '0;
            r_sync_bad <= 1'b0;
            r_cnt      <= '0;
            r_intent   <= '0;
        end else if (i_accept) begin
            r_in_frame <= n_in_frame;
            r_pos      <= n_pos;
            r_len      <= n_len;
            r_sum      <= n_sum;
            r_sync_bad <= n_sync_bad;
            r_cnt      <= n_cnt;
            r_intent   <= n_intent;
        end
    end

    assign o_verdict = verdict;
    assign o_rsp     = rsp;

endmodule

### sv/serial_frame_checker_router.sv
// Top level of the serial frame checker and router.
// Depends on sfcr_pkg, sfcr_cfg_regs and sfcr_frame_track.
//
// Usage:
//   Input channel (i_valid / o_ready / i_req) carries one frame byte per request
//   with a start-of-frame mark. Frames are FF 55, length L, L body bytes, checksum.
//   Output channel (o_valid / i_ready / o_rsp) carries one verdict per completed
//   frame: error flags, intent, counter, length, route and ACK request.
//   Configuration port (i_cfg_we / i_cfg_idx / i_cfg_data) sets the ACK code and
//   the three application intent codes; write only while the block is idle.
// Timing:
//   One byte is accepted per cycle while o_ready is high. The verdict appears in
//   the result register in the cycle after the checksum byte is accepted; the frame
//   state and verdict logic sit between the incoming request and that register.
//   o_ready is high whenever the result register is empty or being drained.
// Reset:
//   Synchronous, active low. Clears frame state, the result valid flag and all
//   intent codes; the block is idle and ignores bytes until a start mark.
// Stall:
//   While i_ready is low a held verdict stays put and o_ready stays low, so no
//   byte is accepted until the verdict is taken.
module serial_frame_checker_router
    import sfcr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  t_in_req              i_req,
    output logic                 o_valid,
    input  logic                 i_ready,
    output t_out_rsp             o_rsp,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [7:0]           i_cfg_data
);

    t_cfg     cfg;
    logic     accept;
    logic     verdict;
    t_out_rsp rsp;
    logic     ready;

    logic     r_out_valid;
    t_out_rsp r_out_rsp;

    // stall input while a held verdict waits
    assign ready  = !r_out_valid || i_ready;
    assign accept = i_valid && ready;

    sfcr_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    sfcr_frame_track u_track (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (accept),
        .i_req     (i_req),
        .i_cfg     (cfg),
        .o_verdict (verdict),
        .o_rsp     (rsp)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && verdict) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && verdict) begin
            r_out_rsp <= rsp;
        end
    end

    assign o_ready = ready;
    assign o_valid = r_out_valid;
    assign o_rsp   = r_out_rsp;

endmodule

### sv/sfcr_checker.sv
// Port-level checks for the serial frame checker and router, bound to the top.
// Depends on sfcr_pkg and serial_frame_checker_router.
module sfcr_checker
    import sfcr_pkg::*;
(
    input logic     i_clk,
    input logic     i_rst_n,
    input logic     i_valid,
    input logic     o_ready,
    input logic     o_valid,
    input logic     i_ready,
    input t_out_rsp o_rsp
);

    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("stalled verdict changed or dropped");

    a_verdict_from_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(o_valid && !i_ready) |-> $past(i_valid && o_ready))
        else $error("verdict without a preceding request");

    a_bad_frame_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.error_flags != 3'd0 |->
            o_rsp.route == ROUTE_DROP && !o_rsp.ack_request)
        else $error("bad frame routed or acknowledged");

    a_ack_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.route == ROUTE_ACK |-> !o_rsp.ack_request)
        else $error("ACK frame requests a reply");

    a_app_needs_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.route == ROUTE_APP |-> o_rsp.ack_request)
        else $error("application frame without ACK request");

endmodule

bind serial_frame_checker_router sfcr_checker u_sfcr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_valid (i_valid),
    .o_ready (o_ready),
    .o_valid (o_valid),
    .i_ready (i_ready),
    .o_rsp   (o_rsp)
);

### verif/tb_top.sv
// Self-checking bench for serial_frame_checker_router: byte frames in, verdicts out.
// Tracks frames itself, predicts each verdict and compares it as it comes out.
// Depends on sfcr_pkg and the serial_frame_checker_router RTL.
module tb_top;
    import sfcr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 100000;

    typedef enum int {
        RCV_OPEN,
        RCV_RANDOM,
        RCV_SPARSE
    } t_rcv_mode;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 in_valid = 1'b0;
    t_in_req              in_req   = '0;
    logic                 rsp_ready = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = CFG_ACK_INTENT;
    logic [7:0]           cfg_data = '0;
    logic                 o_ready;
    logic                 o_valid;
    t_out_rsp             o_rsp;

    t_in_req  byte_q[$];
    t_out_rsp verdict_q[$];
    t_cfg     codes = '0;
    int       fail_cnt = 0;
    int       cycle_cnt = 0;

    logic       in_frm     = 1'b0;
    logic [8:0] pos_r      = '0;
    logic [7:0] len_r      = '0;
    logic [7:0] sum_r      = '0;
    logic       sync_bad_r = 1'b0;
    logic [7:0] cnt_r      = '0;
    logic [7:0] int_r      = '0;

    int        burst_left = 8;
    int        gap_left   = 0;
    int        rcv_cycle  = 0;
    int        hold_left  = 0;
    int        taken      = 0;
    int        next_hold  = 20;
    t_rcv_mode rcv_mode   = RCV_OPEN;

    serial_frame_checker_router uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_valid    (in_valid),
        .o_ready    (o_ready),
        .i_req      (in_req),
        .o_valid    (o_valid),
        .i_ready    (rsp_ready),
        .o_rsp      (o_rsp),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always #1 clk = ~clk;

    task automatic judge_frame_byte(input t_in_req req);
        t_out_rsp   v;
        logic [8:0] pos;
        if (req.frame_start) begin
            in_frm     = 1'b1;
            pos_r      = '0;
            len_r      = '0;
            sum_r      = '0;
            sync_bad_r = 1'b0;
            cnt_r      = '0;
            int_r      = '0;
        end
        if (!in_frm) return;
        pos = pos_r;
        if (pos == 9'd0) begin
            if (req.rx_byte != SYNC_FIRST) sync_bad_r = 1'b1;
        end else if (pos == 9'd1) begin
            if (req.rx_byte != SYNC_SECOND) sync_bad_r = 1'b1;
        end else if (pos == 9'd2) begin
            len_r = req.rx_byte;
        end else if (pos < {1'b0, len_r} + 9'd3) begin
            sum_r = sum_r + req.rx_byte;
            if (pos == 9'd3) cnt_r = req.rx_byte;
            if (pos == 9'd4) int_r = req.rx_byte;
        end else begin
            v = '0;
            v.error_flags[ERR_SYNC]   = sync_bad_r;
            v.error_flags[ERR_LENGTH] = (len_r < MIN_LENGTH);
            v.error_flags[ERR_CSUM]   = (req.rx_byte != 8'h00 - sum_r);
            v.frame_intent  = int_r;
            v.frame_counter = cnt_r;
            v.body_length   = len_r;
            v.route         = ROUTE_DROP;
            if (v.error_flags == 3'b000) begin
                if (int_r == codes.ack_intent_code) begin
                    v.route = ROUTE_ACK;
                end else begin
                    v.ack_request = 1'b1;
                    if (int_r == codes.app_intent_a || int_r == codes.app_intent_b ||
                        int_r == codes.app_intent_c)
                        v.route = ROUTE_APP;
                end
            end
            verdict_q.push_back(v);
            in_frm = 1'b0;
            pos_r  = '0;
            return;
        end
        pos_r = pos + 9'd1;
    endtask

    task automatic check_field(input string what, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $display("%0t mismatch %s: expected %0h actual %0h", $time, what, want, got);
            fail_cnt++;
        end
    endtask

    task automatic queue_frame(input int ln, input logic [7:0] intent, input int fill,
                               input bit spoil_sync, input bit spoil_sum, input int cut);
        logic [7:0] frame_b[$];
        logic [7:0] total;
        logic [7:0] b;
        int         k;
        t_in_req    req;
        total = '0;
        frame_b.push_back(SYNC_FIRST);
        frame_b.push_back(SYNC_SECOND);
        frame_b.push_back(8'(ln));
        if (spoil_sync) begin
            k = $urandom_range(0, 1);
            frame_b[k] = frame_b[k] ^ 8'($urandom_range(1, 255));
        end
        for (k = 0; k < ln; k++) begin
            b = (k == 1) ? intent : (fill < 0) ? 8'($urandom) : 8'(fill);
            total = total + b;
            frame_b.push_back(b);
        end
        b = 8'h00 - total;
        if (spoil_sum) b = b ^ 8'($urandom_range(1, 255));
        frame_b.push_back(b);
        for (k = 0; k < frame_b.size() && (cut < 0 || k < cut); k++) begin
            req.rx_byte     = frame_b[k];
            req.frame_start = (k == 0);
            byte_q.push_back(req);
        end
    endtask

    task automatic queue_noise(input int n, input bit allow_start);
        t_in_req req;
        repeat (n) begin
            req.rx_byte     = 8'($urandom);
            req.frame_start = allow_start && ($urandom_range(0, 7) == 0);
            byte_q.push_back(req);
        end
    endtask

    task automatic queue_random(input int budget);
        int         first;
        int         ln;
        int         pick;
        int         cut;
        logic [7:0] intent;
        first = byte_q.size();
        while (byte_q.size() - first < budget) begin
            if ($urandom_range(0, 99) < 6) queue_noise($urandom_range(1, 4), 1'b1);
            pick = $urandom_range(0, 99);
            if (pick < 8)       ln = $urandom_range(0, 2);
            else if (pick < 90) ln = $urandom_range(3, 10);
            else if (pick < 99) ln = $urandom_range(11, 60);
            else                ln = $urandom_range(200, 255);
            case ($urandom_range(0, 4))
                0: intent = codes.ack_intent_code;
                1: intent = codes.app_intent_a;
                2: intent = codes.app_intent_b;
                3: intent = codes.app_intent_c;
                default: intent = 8'($urandom);
            endcase
            cut = ($urandom_range(0, 99) < 5) ? $urandom_range(1, ln + 3) : -1;
            queue_frame(ln, intent, -1, $urandom_range(0, 99) < 5,
                        $urandom_range(0, 99) < 8, cut);
        end
    endtask

    task automatic apply_codes(input t_cfg c);
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_ACK_INTENT;
        cfg_data <= c.ack_intent_code;
        @(posedge clk);
        cfg_idx  <= CFG_APP_A;
        cfg_data <= c.app_intent_a;
        @(posedge clk);
        cfg_idx  <= CFG_APP_B;
        cfg_data <= c.app_intent_b;
        @(posedge clk);
        cfg_idx  <= CFG_APP_C;
        cfg_data <= c.app_intent_c;
        @(posedge clk);
        cfg_we   <= 1'b0;
        codes = c;
    endtask

    task automatic wait_idle();
        do @(negedge clk);
        while (byte_q.size() != 0 || in_valid || verdict_q.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    // request driver: bursts of random length, random gaps between them
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && o_ready) judge_frame_byte(in_req);
            if (!in_valid || o_ready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    in_valid <= 1'b0;
                end else if (byte_q.size() > 0) begin
                    in_req   <= byte_q.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left == 0) begin
                        burst_left = $urandom_range(1, 48);
                        gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // verdict receiver: own stall pattern plus long hold-offs to back up the input
    always @(posedge clk) begin
        if (!rst_n) begin
            rsp_ready <= 1'b0;
        end else begin
            if (o_valid && rsp_ready) taken++;
            rcv_cycle++;
            if (rcv_cycle % 32 == 0) rcv_mode = t_rcv_mode'($urandom_range(0, 2));
            if (hold_left == 0 && next_hold > 0 && taken >= next_hold) begin
                hold_left = 300;
                next_hold = (next_hold == 20) ? 100 : 0;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ready <= 1'b0;
            end else begin
                case (rcv_mode)
                    RCV_OPEN:   rsp_ready <= 1'b1;
                    RCV_RANDOM: rsp_ready <= 1'($urandom_range(0, 1));
                    default:    rsp_ready <= (rcv_cycle % 3 == 0);
                endcase
            end
        end
    end

    always @(posedge clk) begin
        t_out_rsp want;
        if (rst_n && o_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
                $display("%0t unexpected verdict: expected none actual %0h", $time, o_rsp);
                fail_cnt++;
            end else begin
                want = verdict_q.pop_front();
                check_field("error_flags", 8'(want.error_flags), 8'(o_rsp.error_flags));
                check_field("frame_intent", want.frame_intent, o_rsp.frame_intent);
                check_field("frame_counter", want.frame_counter, o_rsp.frame_counter);
                check_field("body_length", want.body_length, o_rsp.body_length);
                check_field("route", 8'(want.route), 8'(o_rsp.route));
                check_field("ack_request", 8'(want.ack_request), 8'(o_rsp.ack_request));
            end
        end
    end

    always @(posedge clk) begin
        cycle_cnt++;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        apply_codes('{8'h01, 8'h10, 8'h20, 8'h30});
        queue_noise(1, 1'b0);
        queue_frame(0, 8'h00, -1, 1'b0, 1'b0, -1);
        queue_frame(3, 8'h01, 0, 1'b0, 1'b0, -1);
        queue_frame(3, 8'h10, 255, 1'b0, 1'b0, -1);
        queue_frame(5, 8'h20, -1, 1'b0, 1'b0, 1);
        queue_frame(3, 8'h77, -1, 1'b0, 1'b0, -1);
        queue_frame(3, 8'h20, -1, 1'b1, 1'b1, -1);
        queue_random(350);
        wait_idle();

        apply_codes('{8'h00, 8'hFF, 8'hFF, 8'h00});
        queue_frame(255, 8'hFF, -1, 1'b0, 1'b0, -1);
        queue_random(350);
        wait_idle();

        apply_codes('{8'hFF, 8'h00, 8'($urandom), 8'($urandom)});
        queue_random(350);
        wait_idle();

        apply_codes('{8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom)});
        queue_random(350);
        wait_idle();

        repeat (8) @(posedge clk);
        if (fail_cnt == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
